FILE: sv/amc_pkg.sv
// shared constants, types and the arctangent table for the arc midpoint pipeline
package amc_pkg;

  localparam int COORD_WIDTH   = 24;
  localparam int CORDIC_STAGES = 20;
  localparam int FRAC_BITS     = 16;
  // datapath width: coordinate difference, fraction bits and cordic growth
  localparam int DW            = COORD_WIDTH + FRAC_BITS + 5;
  // angle accumulator width, room above a 32-bit binary angle
  localparam int ZW            = 34;
  // stage index width, enough for up to 32 stages
  localparam int IDX_W         = 5;

  localparam logic [29:0] KINV_Q30     = 30'd652032875;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;

  // pipeline positions, counted in register stages after the prep stage
  localparam int POS_MID  = CORDIC_STAGES + 1;
  localparam int POS_B_IN = CORDIC_STAGES + 2;
  localparam int POS_ROT  = 2 * CORDIC_STAGES + 6;
  localparam int POS_LAST = 3 * CORDIC_STAGES + 7;

  typedef struct packed {
    logic             en;
    logic             rot;
    logic [IDX_W-1:0] idx;
  } cell_ctrl_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    logic signed [COORD_WIDTH-1:0] cz;
    logic                          cw;
    logic                          zs;
    logic                          ze;
    logic signed [DW-1:0]          dz;
    logic [31:0]                   mid;
  } side_t;

  function automatic logic [31:0] atan_f(input logic [IDX_W-1:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10680350;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      5'd30: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

FILE: sv/arc_midpoint_from_center.sv
// top level of the arc midpoint pipeline: prep, three cordic cell chains, output skid
// usage:
//   input channel: start, end, center coordinates and the clockwise flag, one arc
//   per transfer, taken at a clock edge with in_valid_i high and in_stall_o low
//   output channel: midpoint x, y, z and the saturated flag, one transfer per arc,
//   taken at a clock edge with out_valid_o high and out_stall_i low
//   path: the prep register, the three cordic chains of one cell a stage,
//   three two-stage gain multipliers, the rotation prep register and the output
//   register lie between input transfer and output valid
//   throughput: one arc per cycle while the skid is empty; every cell then advances its item each cycle
//   reset: all valid bits and the skid flag clear, the pipeline comes up empty
//   stall: while the output register waits, the next finished arc parks in a skid
//   register; only with the skid full does the pipeline freeze and in_stall_o rise
module arc_midpoint_from_center (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  start_x_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  start_y_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  start_z_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  end_x_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  end_y_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  center_x_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  center_y_i,
  input  logic signed [amc_pkg::COORD_WIDTH-1:0]  center_z_i,
  input  logic                                    clockwise_i,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic signed [amc_pkg::COORD_WIDTH-1:0]  mid_x_o,
  output logic signed [amc_pkg::COORD_WIDTH-1:0]  mid_y_o,
  output logic signed [amc_pkg::COORD_WIDTH-1:0]  mid_z_o,
  output logic                                    saturated_o
);

  localparam int CW = amc_pkg::COORD_WIDTH;
  localparam int DW = amc_pkg::DW;
  localparam int ZW = amc_pkg::ZW;
  localparam int N  = amc_pkg::CORDIC_STAGES;
  localparam int L  = amc_pkg::POS_LAST;

  localparam logic signed [DW-1:0] LIM_HI = DW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [DW-1:0] LIM_LO = DW'(-(64'sd1 <<< (CW - 1)));
  localparam logic signed [DW-1:0] RND    = DW'(64'sd1 <<< (amc_pkg::FRAC_BITS - 1));

  // global advance: the whole pipe moves unless the skid holds an item
  logic en;
  logic skid_full_q;
  assign en         = !skid_full_q;
  assign in_stall_o = skid_full_q;

  // valid line and sideband line, one entry per register stage
  logic            v_q [L+1];
  amc_pkg::side_t  sd_q [L+1];

  // ---------------- prep stage: offsets in q16, half-turn fold for x < 0
  logic signed [CW:0]   dsx, dsy, dsz, dex, dey;
  logic signed [DW-1:0] sx_s, sy_s, sz_s, ex_s, ey_s;
  logic signed [DW-1:0] as_x_q, as_y_q, ae_x_q, ae_y_q;
  logic signed [ZW-1:0] as_z_q, ae_z_q;
  amc_pkg::side_t       sd0;

  always_comb begin
    dsx  = (CW+1)'(start_x_i) - (CW+1)'(center_x_i);
    dsy  = (CW+1)'(start_y_i) - (CW+1)'(center_y_i);
    dsz  = (CW+1)'(start_z_i) - (CW+1)'(center_z_i);
    dex  = (CW+1)'(end_x_i)   - (CW+1)'(center_x_i);
    dey  = (CW+1)'(end_y_i)   - (CW+1)'(center_y_i);
    sx_s = DW'(dsx) <<< amc_pkg::FRAC_BITS;
    sy_s = DW'(dsy) <<< amc_pkg::FRAC_BITS;
    sz_s = DW'(dsz) <<< amc_pkg::FRAC_BITS;
    ex_s = DW'(dex) <<< amc_pkg::FRAC_BITS;
    ey_s = DW'(dey) <<< amc_pkg::FRAC_BITS;
    sd0     = '0;
    sd0.cx  = center_x_i;
    sd0.cy  = center_y_i;
    sd0.cz  = center_z_i;
    sd0.cw  = clockwise_i;
    sd0.zs  = (dsx == '0) && (dsy == '0);
    sd0.ze  = (dex == '0) && (dey == '0);
    sd0.dz  = sz_s;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (sx_s < 0) begin
        as_x_q <= -sx_s;
        as_y_q <= -sy_s;
        as_z_q <= ZW'({2'b00, amc_pkg::HALF_TURN});
      end else begin
        as_x_q <= sx_s;
        as_y_q <= sy_s;
        as_z_q <= '0;
      end
      if (ex_s < 0) begin
        ae_x_q <= -ex_s;
        ae_y_q <= -ey_s;
        ae_z_q <= ZW'({2'b00, amc_pkg::HALF_TURN});
      end else begin
        ae_x_q <= ex_s;
        ae_y_q <= ey_s;
        ae_z_q <= '0;
      end
    end
  end

  // ---------------- chain a: start and end angles, start xy length
  logic signed [DW-1:0] sax [N+1];
  logic signed [DW-1:0] say [N+1];
  logic signed [ZW-1:0] saz [N+1];
  logic signed [DW-1:0] eax [N+1];
  logic signed [DW-1:0] eay [N+1];
  logic signed [ZW-1:0] eaz [N+1];

  assign sax[0] = as_x_q;
  assign say[0] = as_y_q;
  assign saz[0] = as_z_q;
  assign eax[0] = ae_x_q;
  assign eay[0] = ae_y_q;
  assign eaz[0] = ae_z_q;

  // ---------------- chain b: 3-d length from xy length and z offset
  logic signed [DW-1:0] bx [N+1];
  logic signed [DW-1:0] by [N+1];
  logic signed [ZW-1:0] bz [N+1];

  // ---------------- chain c: rotation of the radius to the middle angle
  logic signed [DW-1:0] rx [N+1];
  logic signed [DW-1:0] ry [N+1];
  logic signed [ZW-1:0] rz [N+1];

  for (genvar i = 0; i < N; i++) begin : g_cells
    amc_pkg::cell_ctrl_t vctl, rctl;
    assign vctl.en  = en;
    assign vctl.rot = 1'b0;
    assign vctl.idx = amc_pkg::IDX_W'(i);
    assign rctl.en  = en;
    assign rctl.rot = 1'b1;
    assign rctl.idx = amc_pkg::IDX_W'(i);

    amc_cell u_sa (.clk_i, .ctrl_i(vctl), .x_i(sax[i]), .y_i(say[i]), .z_i(saz[i]),
                   .x_o(sax[i+1]), .y_o(say[i+1]), .z_o(saz[i+1]));
    amc_cell u_ea (.clk_i, .ctrl_i(vctl), .x_i(eax[i]), .y_i(eay[i]), .z_i(eaz[i]),
                   .x_o(eax[i+1]), .y_o(eay[i+1]), .z_o(eaz[i+1]));
    amc_cell u_b  (.clk_i, .ctrl_i(vctl), .x_i(bx[i]), .y_i(by[i]), .z_i(bz[i]),
                   .x_o(bx[i+1]), .y_o(by[i+1]), .z_o(bz[i+1]));
    amc_cell u_r  (.clk_i, .ctrl_i(rctl), .x_i(rx[i]), .y_i(ry[i]), .z_i(rz[i]),
                   .x_o(rx[i+1]), .y_o(ry[i+1]), .z_o(rz[i+1]));
  end

  // middle angle from chain a results; zero offsets read as angle zero
  logic [31:0] sa, ea, dang, half, mid;
  always_comb begin
    sa   = sd_q[N].zs ? 32'd0 : saz[N][31:0];
    ea   = sd_q[N].ze ? 32'd0 : eaz[N][31:0];
    dang = sd_q[N].cw ? (sa - ea) : (ea - sa);
    // equal angles sweep a full turn
    half = (dang == 32'd0) ? amc_pkg::HALF_TURN : {1'b0, dang[31:1]};
    mid  = sd_q[N].cw ? (sa - half) : (sa + half);
  end

  // gain removal on the xy length, feeds chain b
  logic [DW-1:0] mxy, m3, rad, rgc;
  amc_kinv_mul u_mul_a (.clk_i, .en_i(en), .a_i(DW'(sax[N])), .p_o(mxy));

  assign bx[0] = signed'(mxy);
  assign by[0] = sd_q[amc_pkg::POS_B_IN].dz;
  assign bz[0] = '0;

  // radius, then the rotation input with gain taken out in advance
  amc_kinv_mul u_mul_b (.clk_i, .en_i(en), .a_i(DW'(bx[N])), .p_o(m3));
  amc_kinv_mul u_mul_c (.clk_i, .en_i(en), .a_i(rad), .p_o(rgc));
  assign rad = m3;

  // rotation prep: fold the angle into the right half plane
  logic [31:0]          au, au_f;
  logic                 flip;
  logic signed [DW-1:0] rp_x_q;
  logic signed [ZW-1:0] rp_z_q;

  always_comb begin
    au   = sd_q[amc_pkg::POS_ROT].mid;
    flip = au[31] ^ au[30];
    au_f = flip ? (au - amc_pkg::HALF_TURN) : au;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      rp_x_q <= flip ? -signed'(rgc) : signed'(rgc);
      rp_z_q <= ZW'(signed'(au_f));
    end
  end

  assign rx[0] = rp_x_q;
  assign ry[0] = '0;
  assign rz[0] = rp_z_q;

  // valid and sideband lines
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= L; k++) v_q[k] <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int k = 1; k <= L; k++) v_q[k] <= v_q[k-1];
    end
  end

  // sideband entering the middle-angle stage picks up the new angle
  amc_pkg::side_t sd_mid;
  always_comb begin
    sd_mid     = sd_q[N];
    sd_mid.mid = mid;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sd_q[0] <= sd0;
      for (int k = 1; k <= L; k++) begin
        sd_q[k] <= (k == amc_pkg::POS_MID) ? sd_mid : sd_q[k-1];
      end
    end
  end

  // ---------------- place: round q16 to micrometres, add center, saturate
  logic signed [DW-1:0] tx, ty, vx, vy;
  logic signed [CW-1:0] px, py;
  logic                 satx, saty;

  always_comb begin
    tx = (rx[N] + RND) >>> amc_pkg::FRAC_BITS;
    ty = (ry[N] + RND) >>> amc_pkg::FRAC_BITS;
    vx = DW'(sd_q[L].cx) + tx;
    vy = DW'(sd_q[L].cy) + ty;
    satx = 1'b0;
    saty = 1'b0;
    if (vx > LIM_HI) begin
      px = LIM_HI[CW-1:0];
      satx = 1'b1;
    end else if (vx < LIM_LO) begin
      px = LIM_LO[CW-1:0];
      satx = 1'b1;
    end else begin
      px = vx[CW-1:0];
    end
    if (vy > LIM_HI) begin
      py = LIM_HI[CW-1:0];
      saty = 1'b1;
    end else if (vy < LIM_LO) begin
      py = LIM_LO[CW-1:0];
      saty = 1'b1;
    end else begin
      py = vy[CW-1:0];
    end
  end

  // ---------------- output register and skid
  logic                 new_v;
  logic                 out_valid_q;
  logic signed [CW-1:0] ox_q, oy_q, oz_q, kx_q, ky_q, kz_q;
  logic                 os_q, ks_q;

  assign new_v = en && v_q[L];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_full_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      out_valid_q <= skid_full_q || new_v;
      skid_full_q <= 1'b0;
    end else if (new_v) begin
      skid_full_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      if (skid_full_q) begin
        ox_q <= kx_q;
        oy_q <= ky_q;
        oz_q <= kz_q;
        os_q <= ks_q;
      end else begin
        ox_q <= px;
        oy_q <= py;
        oz_q <= sd_q[L].cz;
        os_q <= satx | saty;
      end
    end else if (new_v) begin
      kx_q <= px;
      ky_q <= py;
      kz_q <= sd_q[L].cz;
      ks_q <= satx | saty;
    end
  end

  assign out_valid_o = out_valid_q;
  assign mid_x_o     = ox_q;
  assign mid_y_o     = oy_q;
  assign mid_z_o     = oz_q;
  assign saturated_o = os_q;

endmodule

FILE: sv/amc_cell.sv
// one cordic micro-rotation cell, vectoring or rotation, registered
module amc_cell (
  input  logic                              clk_i,
  input  amc_pkg::cell_ctrl_t               ctrl_i,
  input  logic signed [amc_pkg::DW-1:0]     x_i,
  input  logic signed [amc_pkg::DW-1:0]     y_i,
  input  logic signed [amc_pkg::ZW-1:0]     z_i,
  output logic signed [amc_pkg::DW-1:0]     x_o,
  output logic signed [amc_pkg::DW-1:0]     y_o,
  output logic signed [amc_pkg::ZW-1:0]     z_o
);

  logic signed [amc_pkg::DW-1:0] xs, ys, x_d, y_d, x_q, y_q;
  logic signed [amc_pkg::ZW-1:0] a, z_d, z_q;
  logic up;

  always_comb begin
    xs = x_i >>> ctrl_i.idx;
    ys = y_i >>> ctrl_i.idx;
    a  = amc_pkg::ZW'({2'b00, amc_pkg::atan_f(ctrl_i.idx)});
    // rotation drives z to zero, vectoring drives y to zero
    up = ctrl_i.rot ? (z_i < 0) : (y_i >= 0);
    if (up) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + a;
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - a;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      x_q <= x_d;
      y_q <= y_d;
      z_q <= z_d;
    end
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

FILE: sv/amc_kinv_mul.sv
// two-stage gain removal: floor(a * kinv / 2^30) from two partial products
module amc_kinv_mul (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [amc_pkg::DW-1:0]     a_i,
  output logic [amc_pkg::DW-1:0]     p_o
);

  localparam int HW = amc_pkg::DW - 30;

  logic [HW-1:0]           hi;
  logic [29:0]             lo;
  logic [amc_pkg::DW-1:0]  p_hi_q;
  logic [29:0]             p_lo_q;
  logic [59:0]             lo_prod;
  logic [amc_pkg::DW-1:0]  p_q;

  always_comb begin
    hi      = a_i[amc_pkg::DW-1:30];
    lo      = a_i[29:0];
    lo_prod = 60'(lo) * 60'(amc_pkg::KINV_Q30);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_hi_q <= amc_pkg::DW'(hi) * amc_pkg::DW'(amc_pkg::KINV_Q30);
      p_lo_q <= lo_prod[59:30];
      p_q    <= p_hi_q + amc_pkg::DW'(p_lo_q);
    end
  end

  assign p_o = p_q;

endmodule
